>>> rtl/csvt_pkg.sv
// csvt_pkg: shared types and constants of the csv field tokenizer
// payload structs, result kinds and the classified token passed front to back
// no dependencies

package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0]  DELIM_RESET = 8'd44;
    localparam logic [23:0] LINE_MAX    = 24'hFFFFFF;
    localparam logic [23:0] LINE_FIRST  = 24'd1;

    typedef enum logic [2:0] {
        KIND_BYTE  = 3'd0,
        KIND_FIELD = 3'd1,
        KIND_ROW   = 3'd2,
        KIND_TRUNC = 3'd3,
        KIND_NLQ   = 3'd4,
        KIND_COLS  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } csv_in_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [6:0]  column;
        logic [7:0]  position;
        logic [23:0] line_number;
    } csv_out_t;

    // byte with its character classes resolved
    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
        logic       is_quote;
        logic       is_cr;
        logic       is_lf;
        logic       is_delim;
        logic       is_space;
    } tok_t;

endpackage

>>> rtl/csvt_front.sv
// csvt_front: input handshake, delimiter register and byte classification
// depends on csvt_pkg; feeds csvt_queue

module csvt_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  csvt_pkg::csv_in_t s_data,
    input  logic             q_full,
    output logic             q_push,
    output csvt_pkg::tok_t   q_tok
);
    import csvt_pkg::*;

    logic [7:0] delim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= DELIM_RESET;
        end else if (cfg_wr_en) begin
            delim_reg <= cfg_wr_data;
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_tok.ch       = s_data.ch;
        q_tok.is_end   = s_data.is_end;
        q_tok.is_quote = (s_data.ch == CH_QUOTE);
        q_tok.is_cr    = (s_data.ch == CH_CR);
        q_tok.is_lf    = (s_data.ch == CH_LF);
        q_tok.is_delim = (s_data.ch == delim_reg);
        q_tok.is_space = (s_data.ch == CH_SPACE);
    end

endmodule

>>> rtl/csvt_queue.sv
// csvt_queue: two-entry token queue between front and back
// depends on csvt_pkg

module csvt_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  csvt_pkg::tok_t push_tok,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output csvt_pkg::tok_t head_tok
);
    import csvt_pkg::*;

    tok_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign avail    = (count_reg != 2'd0);
    assign head_tok = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

>>> rtl/csvt_back.sv
// csvt_back: tokenizer state, event generation and the result register
// depends on csvt_pkg; drains csvt_queue

module csvt_back #(
    parameter int MAX_FIELDS    = 64,
    parameter int MAX_FIELD_LEN = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_avail,
    input  csvt_pkg::tok_t     q_tok,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output csvt_pkg::csv_out_t m_data
);
    import csvt_pkg::*;

    localparam int COL_W = $clog2(MAX_FIELDS + 1);
    localparam int LEN_W = $clog2(MAX_FIELD_LEN);
    localparam logic [COL_W:0] COL_LIMIT = (COL_W + 1)'(MAX_FIELDS);
    localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W + 1)'(MAX_FIELD_LEN);

    logic             quoted_reg, quoted_next;
    logic             started_reg, started_next;
    logic             trunc_reg, trunc_next;
    logic             after_cr_reg, after_cr_next;
    logic             halted_reg, halted_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [23:0]      line_reg, line_next;
    logic             out_valid_reg, out_valid_next;
    csv_out_t         out_reg, out_next;

    logic             emit;
    csv_out_t         res;
    logic [COL_W:0]   col_inc;
    logic [LEN_W:0]   len_inc;
    logic             row_end;

    assign q_pop   = q_avail && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign len_inc = {1'b0, len_reg} + 1'b1;

    always_comb begin
        quoted_next   = quoted_reg;
        started_next  = started_reg;
        trunc_next    = trunc_reg;
        after_cr_next = after_cr_reg;
        halted_next   = halted_reg;
        col_next      = col_reg;
        len_next      = len_reg;
        line_next     = line_reg;
        emit          = 1'b0;
        row_end       = 1'b0;

        res.kind        = KIND_BYTE;
        res.data_byte   = 8'd0;
        res.column      = 7'(col_reg);
        res.position    = 8'(len_reg);
        res.line_number = line_reg;

        if (q_pop && !halted_reg) begin
            if (q_tok.is_end) begin
                row_end = 1'b1;
            end else begin
                after_cr_next = 1'b0;
                // after a cr, quote and cr bytes lose their meaning
                if (!after_cr_reg && q_tok.is_quote) begin
                    quoted_next  = !quoted_reg;
                    started_next = !quoted_reg;
                end else if (!after_cr_reg && q_tok.is_cr) begin
                    after_cr_next = 1'b1;
                end else if (q_tok.is_lf) begin
                    if (!quoted_reg) begin
                        row_end = 1'b1;
                    end else begin
                        halted_next = 1'b1;
                        emit        = 1'b1;
                        res.kind    = KIND_NLQ;
                    end
                end else if (q_tok.is_delim && !quoted_reg) begin
                    started_next = 1'b0;
                    trunc_next   = 1'b0;
                    len_next     = '0;
                    emit         = 1'b1;
                    if (col_inc >= COL_LIMIT) begin
                        col_next    = COL_W'(MAX_FIELDS);
                        halted_next = 1'b1;
                        res.kind    = KIND_COLS;
                        res.column  = 7'(MAX_FIELDS);
                    end else begin
                        col_next = col_inc[COL_W-1:0];
                        res.kind = KIND_FIELD;
                    end
                end else if (started_reg || !q_tok.is_space) begin
                    started_next = 1'b1;
                    if (!trunc_reg) begin
                        emit = 1'b1;
                        if (len_inc >= LEN_LIMIT) begin
                            trunc_next = 1'b1;
                            res.kind   = KIND_TRUNC;
                        end else begin
                            len_next      = len_inc[LEN_W-1:0];
                            res.data_byte = q_tok.ch;
                        end
                    end
                end
            end

            if (row_end) begin
                emit          = 1'b1;
                res.kind      = KIND_ROW;
                res.column    = 7'(col_inc);
                quoted_next   = 1'b0;
                started_next  = 1'b0;
                trunc_next    = 1'b0;
                after_cr_next = 1'b0;
                col_next      = '0;
                len_next      = '0;
                if (line_reg != LINE_MAX) begin
                    line_next = line_reg + 24'd1;
                end
            end
        end

        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quoted_reg    <= 1'b0;
            started_reg   <= 1'b0;
            trunc_reg     <= 1'b0;
            after_cr_reg  <= 1'b0;
            halted_reg    <= 1'b0;
            col_reg       <= '0;
            len_reg       <= '0;
            line_reg      <= LINE_FIRST;
            out_valid_reg <= 1'b0;
        end else begin
            quoted_reg    <= quoted_next;
            started_reg   <= started_next;
            trunc_reg     <= trunc_next;
            after_cr_reg  <= after_cr_next;
            halted_reg    <= halted_next;
            col_reg       <= col_next;
            len_reg       <= len_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

>>> rtl/csv_field_tokenizer_core.sv
// csv_field_tokenizer_core: top level of the streaming csv field tokenizer
// depends on csvt_pkg, csvt_front, csvt_queue and csvt_back
//
// The tokenizer takes one byte (or an end-of-stream marker) per clock while s_ready is
// high and gives at most one event per byte: a stored field byte, a field end, a row
// end with its field count, a truncation notice, or a sticky error that stops all
// output until reset. Throughput is one byte per cycle while the result register is not
// held by m_ready, set by the state update in the back end; a result passes through the
// token queue entry and then the result register before it shows on m_valid/m_data.
// A two-entry queue separates the classifying front end from the back end, so while a
// result waits on m_ready the input still takes requests until both queue entries are
// filled, then s_ready drops. The delimiter register (reset value comma) is written
// through cfg_wr_en/cfg_wr_data and should only change while the block is idle.

module csv_field_tokenizer_core #(
    parameter int MAX_FIELDS    = 64,
    parameter int MAX_FIELD_LEN = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  csvt_pkg::csv_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output csvt_pkg::csv_out_t m_data
);
    import csvt_pkg::*;

    logic q_full;
    logic q_push;
    tok_t q_in_tok;
    logic q_pop;
    logic q_avail;
    tok_t q_head_tok;

    csvt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_tok       (q_in_tok)
    );

    csvt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_tok (q_in_tok),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head_tok (q_head_tok)
    );

    csvt_back #(
        .MAX_FIELDS    (MAX_FIELDS),
        .MAX_FIELD_LEN (MAX_FIELD_LEN)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_avail (q_avail),
        .q_tok   (q_head_tok),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/csvt_checker.sv
// csvt_checker: port-level assertions for csv_field_tokenizer_core
// depends on csvt_pkg; bound to the top level at the end of this file

module csvt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input csvt_pkg::csv_out_t m_data
);
    import csvt_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // errors are sticky: nothing follows an accepted error event
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_data.kind == KIND_NLQ || m_data.kind == KIND_COLS)
        |=> !m_valid)
        else $error("result after sticky error");

    // only byte events carry data
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_BYTE |-> m_data.data_byte == 8'd0)
        else $error("non-byte event with data");

    // a row always counts at least one field, line numbers start at one
    a_row_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_ROW |-> m_data.column != 7'd0
            && m_data.line_number != 24'd0)
        else $error("row end with zero field count or line");

endmodule

bind csv_field_tokenizer_core csvt_checker u_csvt_checker (.*);
